[design/pmd_pkg.sv]
// Package for the padded message deframer: status codes, result record,
// padded-size function and counter limits.
// Depends on nothing; imported by pmd_out_buf and padded_message_deframer.
`default_nettype none

package pmd_pkg;

  // Byte counter width and its saturation value.
  localparam int unsigned CountW = 18;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Smallest well-formed message: two header bytes and 32 padded bytes.
  localparam int unsigned MinTotal = 34;

  // Completion status reported on the final byte.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_ZERO_LENGTH = 3'd2,
    ST_SIZE_MISMTCH = 3'd3,
    ST_PAD_NONZERO = 3'd4
  } pmd_status_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  content_byte;
    logic        content_valid;
    logic        done_res;
    logic [15:0] content_length;
    pmd_status_t status;
  } pmd_result_t;

  // Padded size for a content length. Lengths up to 32 pad to 32. Above that,
  // the chunk is 32 while the next power of two is at most 256, and an eighth
  // of that power otherwise; the length is rounded up to whole chunks.
  function automatic logic [16:0] padded_size(input logic [15:0] len);
    logic [15:0] x;
    logic [4:0]  msb;
    logic [16:0] mask;
    logic [16:0] rounded;
    x   = len - 16'd1;
    msb = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        msb = 5'(i);
      end
    end
    // The power of two is 2^(msb+1), so an eighth of it is 2^(msb-2).
    if (msb >= 5'd8) begin
      mask = (17'd1 << (msb - 5'd2)) - 17'd1;
    end else begin
      mask = 17'd31;
    end
    rounded = ({1'b0, len} + mask) & ~mask;
    if (len <= 16'd32) begin
      rounded = 17'd32;
    end
    return rounded;
  endfunction

endpackage

`default_nettype wire

[design/pmd_out_buf.sv]
// Output stage of the padded message deframer: a result register with a
// one-entry skid register behind it. Depends on pmd_pkg.
`default_nettype none

module pmd_out_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pmd_pkg::pmd_result_t push_data,
  output logic                     full,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output pmd_pkg::pmd_result_t     res_data
);
  import pmd_pkg::*;

  logic        skid_valid;
  pmd_result_t skid_data;
  logic        out_take;
  logic        out_load;

  // The output register takes a new result when it is empty or being drained.
  assign out_take = res_valid & ~res_stall;
  assign out_load = ~skid_valid & (~res_valid | out_take);
  assign full     = skid_valid;

  // Control: valid flags of the output and skid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (out_load) begin
      res_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: moves with the valid flags and needs no reset.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        res_data <= skid_data;
      end
    end else if (out_load) begin
      res_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // The skid register only fills behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid register holds data while output register is empty");

  // Upstream is held off while the skid register is full.
  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into a full output stage");

  // A result that meets a stalled output lands in the skid register.
  a_push_to_skid : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall && push) |=> skid_valid)
    else $error("result lost while output was stalled");

endmodule

`default_nettype wire

[design/padded_message_deframer.sv]
// Top level of the padded message deframer: header capture, content and
// padding classification, final status. Depends on pmd_pkg and pmd_out_buf.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  message  | msg_valid, msg_stall | data_byte, last_byte
//  result   | res_valid, res_stall | content_byte, content_valid, done_res,
//           |                      | content_length, status
//
// One byte is accepted per cycle while msg_stall is low; its result, if any, is
// registered in the output register, or in the skid register behind it.
// Header and non-final padding bytes give no result transaction.
// Reset clears the byte count and header state; no clearing pass follows.
// A stalled result waits in the output register while one more byte is taken
// into the skid register; msg_stall then rises until the skid drains.
`default_nettype none

module padded_message_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       content_byte,
  output logic             content_valid,
  output logic             done_res,
  output logic [15:0]      content_length,
  output pmd_pkg::pmd_status_t status
);
  import pmd_pkg::*;

  logic              msg_accept;
  logic [CountW-1:0] byte_count;
  logic [CountW-1:0] byte_count_next;
  logic [7:0]        length_high;
  logic [7:0]        length_high_next;
  logic [15:0]       message_length;
  logic [15:0]       message_length_next;
  logic [16:0]       frame_size;
  logic [16:0]       frame_size_next;
  logic              padding_nonzero;
  logic              padding_nonzero_next;
  logic [CountW-1:0] content_limit;
  logic [CountW:0]   total;
  logic              is_content;
  logic              push;
  pmd_result_t       result;
  pmd_result_t       res_data;
  pmd_status_t       final_status;
  logic              buf_full;

  assign msg_accept = msg_valid & ~msg_stall;
  assign msg_stall  = buf_full;

  // Content occupies the bytes after the header, up to two plus the length.
  assign content_limit = CountW'({1'b0, message_length} + 17'd2);
  assign total         = {1'b0, byte_count} + 19'd1;

  // Byte classification and state update for the byte on the input.
  always_comb begin
    byte_count_next      = byte_count;
    length_high_next     = length_high;
    message_length_next  = message_length;
    frame_size_next      = frame_size;
    padding_nonzero_next = padding_nonzero;
    is_content           = 1'b0;
    if (byte_count == '0) begin
      length_high_next = data_byte;
    end else if (byte_count == CountW'(1)) begin
      message_length_next = {length_high, data_byte};
    end else begin
      // The padded size follows from the stored length one byte later.
      if (byte_count == CountW'(2)) begin
        frame_size_next = padded_size(message_length) + 17'd2;
      end
      if (byte_count != CountMax && byte_count < content_limit) begin
        is_content = 1'b1;
      end else if (data_byte != 8'd0) begin
        padding_nonzero_next = 1'b1;
      end
    end
    if (byte_count != CountMax) begin
      byte_count_next = byte_count + CountW'(1);
    end
  end

  // Final status, first failing check wins.
  always_comb begin
    if (total < 19'(MinTotal)) begin
      final_status = ST_TOO_SHORT;
    end else if (message_length_next == 16'd0) begin
      final_status = ST_ZERO_LENGTH;
    end else if (total != {2'b00, frame_size}) begin
      final_status = ST_SIZE_MISMTCH;
    end else if (padding_nonzero_next) begin
      final_status = ST_PAD_NONZERO;
    end else begin
      final_status = ST_OK;
    end
  end

  // Result record for the byte on the input.
  always_comb begin
    push                  = msg_accept & (is_content | last_byte);
    result.content_byte   = is_content ? data_byte : 8'd0;
    result.content_valid  = is_content;
    result.done_res       = last_byte;
    result.content_length = 16'd0;
    result.status         = ST_OK;
    if (last_byte) begin
      result.status = final_status;
      if (byte_count == '0) begin
        result.content_length = {data_byte, 8'd0};
      end else begin
        result.content_length = message_length_next;
      end
    end
  end

  // Frame state; the final byte returns everything to its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      length_high     <= '0;
      message_length  <= '0;
      frame_size      <= '0;
      padding_nonzero <= 1'b0;
    end else if (msg_accept) begin
      if (last_byte) begin
        byte_count      <= '0;
        length_high     <= '0;
        message_length  <= '0;
        frame_size      <= '0;
        padding_nonzero <= 1'b0;
      end else begin
        byte_count      <= byte_count_next;
        length_high     <= length_high_next;
        message_length  <= message_length_next;
        frame_size      <= frame_size_next;
        padding_nonzero <= padding_nonzero_next;
      end
    end
  end

  pmd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (buf_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  assign content_byte   = res_data.content_byte;
  assign content_valid  = res_data.content_valid;
  assign done_res       = res_data.done_res;
  assign content_length = res_data.content_length;
  assign status         = res_data.status;

  // The final byte of a message leaves the frame state cleared.
  a_frame_restart : assert property (@(posedge clk) disable iff (rst)
    (msg_accept && last_byte) |=> (byte_count == '0 && !padding_nonzero))
    else $error("frame state not cleared after final byte");

  // A result that is not the final one is always a content byte with no status.
  a_mid_result_content : assert property (@(posedge clk) disable iff (rst)
    (push && !last_byte) |-> (is_content && result.status == ST_OK))
    else $error("non-final result is not a plain content byte");

  // The byte counter holds at its ceiling.
  a_count_saturates : assert property (@(posedge clk) disable iff (rst)
    (msg_accept && !last_byte && byte_count == CountMax) |=> byte_count == CountMax)
    else $error("byte counter wrapped past its ceiling");

endmodule

`default_nettype wire
